[rtl/irm_pkg.sv]
// Shared types and constants for the Ising ring Metropolis update block.
// Used by irm_spin_ram, irm_flip_eval and ising_ring_metropolis_update.
package irm_pkg;

    // Ring geometry: spins are stored as rows of ROW_W bits
    localparam int SITES  = 2048;
    localparam int ROW_W  = 32;
    localparam int ROWS   = SITES / ROW_W;
    localparam int ROW_AW = $clog2(ROWS);
    localparam int BIT_W  = $clog2(ROW_W);

    // Field widths of the stream beats
    localparam int SITE_W = 11;
    localparam int RND_W  = 16;
    localparam int THR_W  = 16;
    localparam int SUM_W  = 13;
    localparam int MAG_W  = 12;
    localparam int RES_W  = 1 + MAG_W + SUM_W;
    localparam int TDATA_W = 32;

    // Item kinds carried in tuser
    localparam logic OP_INIT  = 1'b0;
    localparam logic OP_TRIAL = 1'b1;

    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [ROW_AW-1:0] t_row_addr;
    typedef logic [BIT_W-1:0]  t_bit_idx;

    // Outcome of one trial, handed from the evaluator to the sequencer
    typedef struct packed {
        logic               flip;
        t_row               new_row;
        logic signed [SUM_W-1:0] next_sum;
        logic signed [SUM_W-1:0] next_energy;
    } t_eval;

endpackage

[rtl/irm_spin_ram.sv]
// Spin storage: ROWS x ROW_W bits, one write port, two registered read ports.
// Depends on irm_pkg for row types.
module irm_spin_ram (
    input  logic               i_clk,
    input  logic               i_we,
    input  irm_pkg::t_row_addr i_waddr,
    input  irm_pkg::t_row      i_wdata,
    input  logic               i_re,
    input  irm_pkg::t_row_addr i_raddr_a,
    input  irm_pkg::t_row_addr i_raddr_b,
    output irm_pkg::t_row      o_rdata_a,
    output irm_pkg::t_row      o_rdata_b
);

    irm_pkg::t_row r_mem [irm_pkg::ROWS];
    irm_pkg::t_row r_rdata_a;
    irm_pkg::t_row r_rdata_b;

    // Write the row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read both rows into the output registers
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/irm_flip_eval.sv]
// Metropolis decision for one site: neighbor lookup, energy class, accept test,
// updated row and sums. Depends on irm_pkg for row types and t_eval.
module irm_flip_eval (
    input  irm_pkg::t_row                       i_row_a,
    input  irm_pkg::t_row                       i_row_b,
    input  irm_pkg::t_bit_idx                   i_bit,
    input  logic                                i_in_range,
    input  logic [irm_pkg::RND_W-1:0]           i_rnd,
    input  logic [irm_pkg::THR_W-1:0]           i_thr,
    input  logic signed [irm_pkg::SUM_W-1:0]    i_spin_sum,
    input  logic signed [irm_pkg::SUM_W-1:0]    i_energy,
    output irm_pkg::t_eval                      o_eval
);

    irm_pkg::t_bit_idx bit_m1;
    irm_pkg::t_bit_idx bit_p1;
    logic spin;
    logic left_spin;
    logic right_spin;
    logic uphill;
    logic downhill;
    logic flip;

    // Pick the spin and its two neighbors; edges of the row come from row b
    assign bit_m1     = i_bit - 1'b1;
    assign bit_p1     = i_bit + 1'b1;
    assign spin       = i_row_a[i_bit];
    assign left_spin  = (i_bit == '0) ? i_row_b[irm_pkg::ROW_W-1] : i_row_a[bit_m1];
    assign right_spin = (i_bit == irm_pkg::BIT_W'(irm_pkg::ROW_W-1)) ? i_row_b[0]
                                                                    : i_row_a[bit_p1];

    // Energy change is +4 when both neighbors agree with the spin, -4 when both differ
    assign uphill   = (left_spin == spin) && (right_spin == spin);
    assign downhill = (left_spin != spin) && (right_spin != spin);
    assign flip     = i_in_range && (!uphill || (i_rnd <= i_thr));

    // Build the updated row and sums
    always_comb begin
        o_eval.flip        = flip;
        o_eval.new_row     = i_row_a ^ (irm_pkg::ROW_W'(1) << i_bit);
        o_eval.next_sum    = i_spin_sum;
        o_eval.next_energy = i_energy;
        if (flip) begin
            o_eval.next_sum = spin ? (i_spin_sum - irm_pkg::SUM_W'(2))
                                   : (i_spin_sum + irm_pkg::SUM_W'(2));
            if (uphill) begin
                o_eval.next_energy = i_energy + irm_pkg::SUM_W'(4);
            end else if (downhill) begin
                o_eval.next_energy = i_energy - irm_pkg::SUM_W'(4);
            end
        end
    end

endmodule

[rtl/ising_ring_metropolis_update.sv]
// Metropolis update of a 1-D Ising ring of 2048 spins (J = 1). A trial beat
// (tuser = 1) issues, in the accepting cycle, the registered read of the
// site's row and its neighbor row from the spin RAM; the next cycle decides,
// writes the row back and loads the result into the output register, and no
// new beat is taken before that trial is decided. An init beat (tuser = 0)
// sets all spins up with a clearing pass that writes all 64 rows of the spin
// RAM (one 32-bit row per cycle), then returns its result; the same clearing
// pass runs after reset, during which no beat is accepted (threshold writes
// are always taken). One result beat follows every input beat; a finished
// result waits in the output register while the next input beat is taken, and a
// second result that finds the output register full is held and stalls the input.
module ising_ring_metropolis_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Acceptance threshold register
    input  logic                          i_cfg_we,
    input  logic [irm_pkg::THR_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [irm_pkg::TDATA_W-1:0]   s_tdata,   // site_index[10:0], random_value[26:11]
    input  logic [0:0]                    s_tuser,   // opcode[0]
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [irm_pkg::TDATA_W-1:0]   m_tdata    // flipped[0], magnetization_abs[12:1],
                                                     // total_energy[25:13]
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;
    localparam logic [1:0] ST_PEND  = 2'd3;

    logic [1:0]                          r_state,  n_state;
    irm_pkg::t_row_addr                  r_clr_row, n_clr_row;
    logic                                r_init,   n_init;
    logic signed [irm_pkg::SUM_W-1:0]    r_spin_sum, n_spin_sum;
    logic signed [irm_pkg::SUM_W-1:0]    r_energy, n_energy;
    logic [irm_pkg::THR_W-1:0]           r_thr;
    irm_pkg::t_bit_idx                   r_bit;
    irm_pkg::t_row_addr                  r_row;
    logic [irm_pkg::RND_W-1:0]           r_rnd;
    logic                                r_in_range;
    logic [irm_pkg::RES_W-1:0]           r_pend;
    logic                                r_m_tvalid;
    logic [irm_pkg::TDATA_W-1:0]         r_m_tdata;

    logic                                accept;
    logic                                out_free;
    logic [irm_pkg::SITE_W-1:0]          in_site;
    irm_pkg::t_bit_idx                   in_bit;
    irm_pkg::t_row_addr                  in_row;
    irm_pkg::t_row_addr                  nb_row;
    logic                                mem_we;
    irm_pkg::t_row_addr                  mem_waddr;
    irm_pkg::t_row                       mem_wdata;
    irm_pkg::t_row                       row_a;
    irm_pkg::t_row                       row_b;
    irm_pkg::t_eval                      ev;
    logic                                res_valid;
    logic                                res_flip;
    logic signed [irm_pkg::SUM_W-1:0]    abs_sum;
    logic [irm_pkg::RES_W-1:0]           res_data;

    // Handshake
    assign s_tready = (r_state == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !r_m_tvalid || m_tready;

    // Split the site into row and bit; pick the neighbor row for edge bits
    assign in_site = s_tdata[irm_pkg::SITE_W-1:0];
    assign in_bit  = in_site[irm_pkg::BIT_W-1:0];
    assign in_row  = in_site[irm_pkg::BIT_W +: irm_pkg::ROW_AW];
    always_comb begin
        if (in_bit == '0) begin
            nb_row = (in_row == '0) ? irm_pkg::ROW_AW'(irm_pkg::ROWS-1) : in_row - 1'b1;
        end else begin
            nb_row = (in_row == irm_pkg::ROW_AW'(irm_pkg::ROWS-1)) ? '0 : in_row + 1'b1;
        end
    end

    irm_spin_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (accept),
        .i_raddr_a (in_row),
        .i_raddr_b (nb_row),
        .o_rdata_a (row_a),
        .o_rdata_b (row_b)
    );

    irm_flip_eval u_eval (
        .i_row_a    (row_a),
        .i_row_b    (row_b),
        .i_bit      (r_bit),
        .i_in_range (r_in_range),
        .i_rnd      (r_rnd),
        .i_thr      (r_thr),
        .i_spin_sum (r_spin_sum),
        .i_energy   (r_energy),
        .o_eval     (ev)
    );

    // Sequencer: clearing pass, trial read, write-back, result hand-off
    always_comb begin
        n_state    = r_state;
        n_clr_row  = r_clr_row;
        n_init     = r_init;
        n_spin_sum = r_spin_sum;
        n_energy   = r_energy;
        mem_we     = 1'b0;
        mem_waddr  = r_row;
        mem_wdata  = ev.new_row;
        res_valid  = 1'b0;
        res_flip   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_row;
                mem_wdata = '1;
                n_clr_row = r_clr_row + 1'b1;
                if (r_clr_row == irm_pkg::ROW_AW'(irm_pkg::ROWS-1)) begin
                    n_clr_row = '0;
                    n_init    = 1'b0;
                    if (r_init) begin
                        res_valid = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] == irm_pkg::OP_INIT) begin
                        n_state    = ST_CLEAR;
                        n_init     = 1'b1;
                        n_spin_sum = irm_pkg::SUM_W'(irm_pkg::SITES);
                        n_energy   = -irm_pkg::SUM_W'(irm_pkg::SITES);
                    end else begin
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                mem_we     = ev.flip;
                res_valid  = 1'b1;
                res_flip   = ev.flip;
                n_spin_sum = ev.next_sum;
                n_energy   = ev.next_energy;
            end
            ST_PEND: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (res_valid) begin
            n_state = out_free ? ST_IDLE : ST_PEND;
        end
    end

    // Pack the result from the updated sums
    assign abs_sum  = n_spin_sum[irm_pkg::SUM_W-1] ? -n_spin_sum : n_spin_sum;
    assign res_data = {n_energy, abs_sum[irm_pkg::MAG_W-1:0], res_flip};

    // Control state and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_row  <= '0;
            r_init     <= 1'b0;
            r_spin_sum <= irm_pkg::SUM_W'(irm_pkg::SITES);
            r_energy   <= -irm_pkg::SUM_W'(irm_pkg::SITES);
            r_thr      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_row  <= n_clr_row;
            r_init     <= n_init;
            r_spin_sum <= n_spin_sum;
            r_energy   <= n_energy;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if ((res_valid && out_free) || (r_state == ST_PEND && out_free)) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Latch the trial item and move results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bit      <= in_bit;
            r_row      <= in_row;
            r_rnd      <= s_tdata[irm_pkg::SITE_W +: irm_pkg::RND_W];
            r_in_range <= (32'(in_site) < irm_pkg::SITES);
        end
        if (res_valid && !out_free) begin
            r_pend <= res_data;
        end
        if (res_valid && out_free) begin
            r_m_tdata <= {{(irm_pkg::TDATA_W-irm_pkg::RES_W){1'b0}}, res_data};
        end else if (r_state == ST_PEND && out_free) begin
            r_m_tdata <= {{(irm_pkg::TDATA_W-irm_pkg::RES_W){1'b0}}, r_pend};
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;

    // A held result always sits behind a full output register
    a_pend_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PEND) |-> r_m_tvalid)
        else $error("pending result without a full output register");

    // Trial write-back only for sites on the ring
    a_wb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK && mem_we) |-> r_in_range)
        else $error("row written for an out-of-range site");

    // A flip moves the spin sum by exactly two
    a_sum_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK && ev.flip) |=>
        ((r_spin_sum - $past(r_spin_sum) == irm_pkg::SUM_W'(2)) ||
         ($past(r_spin_sum) - r_spin_sum == irm_pkg::SUM_W'(2))))
        else $error("spin sum moved by other than two");

    // Ring energy of an even ring stays even
    a_energy_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |=> (r_energy[0] == 1'b0))
        else $error("ring energy became odd");

endmodule
